// ===== src/cal_clk_pkg.sv =====
// Types, constants and month-length function for the calendar clock counter.
`default_nettype none
package cal_clk_pkg;

    localparam int YEAR_W = 12;
    localparam int MON_W  = 4;
    localparam int DAY_W  = 5;
    localparam int HOUR_W = 5;
    localparam int MIN_W  = 6;
    localparam int SEC_W  = 6;

    localparam logic [SEC_W-1:0]  SEC_MAX  = 6'd59;
    localparam logic [MIN_W-1:0]  MIN_MAX  = 6'd59;
    localparam logic [HOUR_W-1:0] HOUR_MAX = 5'd23;
    localparam logic [MON_W-1:0]  MON_MAX  = 4'd12;
    localparam logic [MON_W-1:0]  MON_MIN  = 4'd1;
    localparam logic [DAY_W-1:0]  DAY_MIN  = 5'd1;

    localparam logic [MON_W-1:0]  MON_FEB = 4'd2;
    localparam logic [MON_W-1:0]  MON_APR = 4'd4;
    localparam logic [MON_W-1:0]  MON_JUN = 4'd6;
    localparam logic [MON_W-1:0]  MON_SEP = 4'd9;
    localparam logic [MON_W-1:0]  MON_NOV = 4'd11;

    localparam logic [YEAR_W-1:0] YEAR_RST     = 12'd2008;
    localparam logic [MON_W-1:0]  MON_RST      = 4'd2;
    localparam logic [DAY_W-1:0]  DAY_RST      = 5'd28;
    localparam logic [HOUR_W-1:0] HOUR_RST     = 5'd23;
    localparam logic [MIN_W-1:0]  MIN_RST      = 6'd59;
    localparam logic [SEC_W-1:0]  SEC_RST      = 6'd57;
    localparam logic [YEAR_W-1:0] YEAR_LO_RST  = 12'd2016;
    localparam logic [YEAR_W-1:0] YEAR_HI_RST  = 12'd2030;

    typedef enum logic [1:0] {
        CMD_TICK = 2'd0,
        CMD_INC  = 2'd1,
        CMD_DEC  = 2'd2
    } cmd_t;

    typedef enum logic [2:0] {
        FLD_SEC  = 3'd0,
        FLD_MIN  = 3'd1,
        FLD_HOUR = 3'd2,
        FLD_DAY  = 3'd3,
        FLD_MON  = 3'd4,
        FLD_YEAR = 3'd5
    } field_t;

    typedef enum logic {
        REG_YEAR_LO = 1'b0,
        REG_YEAR_HI = 1'b1
    } cfg_reg_t;

    function automatic logic [DAY_W-1:0] month_len(input logic [MON_W-1:0] mon,
                                                   input logic [YEAR_W-1:0] year);
        logic [DAY_W-1:0] len;
        if (mon == MON_FEB) begin
            len = (year[1:0] == 2'b00) ? 5'd29 : 5'd28;
        end else if (mon == MON_APR || mon == MON_JUN || mon == MON_SEP
                     || mon == MON_NOV) begin
            len = 5'd30;
        end else begin
            len = 5'd31;
        end
        return len;
    endfunction

endpackage
`default_nettype wire

// ===== src/calendar_clock_counter.sv =====
// Calendar clock counter: 24-hour date/time with tick and field edit words.
// The result word is registered: it appears in the cycle after its input word is accepted.
// Throughput: one word per cycle while m_tready is high; the date/time registers form the result register.
// s_tready is high while the result slot is empty or being taken this cycle.
// Reset (aresetn low, synchronous): date/time to 2008-02-28 23:59:57,
// year bounds to 2016..2030, no result pending.
`default_nettype none
module calendar_clock_counter
    import cal_clk_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // command[1:0], field_select[4:2], zero pad
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [39:0]      m_tdata,   // year_out[11:0], month_out[15:12], day_out[20:16],
                                        // hour_out[25:21], minute_out[31:26],
                                        // second_out[37:32], zero pad
    input  wire logic        cfg_wr_en,
    input  wire logic        cfg_addr,
    input  wire logic [11:0] cfg_wdata
);

    logic [YEAR_W-1:0] year_reg, year_next;
    logic [MON_W-1:0]  mon_reg, mon_next;
    logic [DAY_W-1:0]  day_reg, day_next;
    logic [HOUR_W-1:0] hour_reg, hour_next;
    logic [MIN_W-1:0]  min_reg, min_next;
    logic [SEC_W-1:0]  sec_reg, sec_next;
    logic [YEAR_W-1:0] year_lo_reg, year_hi_reg;
    logic              m_tvalid_reg;
    logic              accept;
    cmd_t              cmd;
    field_t            fld;
    logic [DAY_W-1:0]  len;

    assign s_tready = !m_tvalid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {2'b00, sec_reg, min_reg, hour_reg, day_reg, mon_reg, year_reg};
    assign cmd      = cmd_t'(s_tdata[1:0]);
    assign fld      = field_t'(s_tdata[4:2]);
    assign len      = month_len(mon_reg, year_reg);

    always_comb begin
        year_next = year_reg;
        mon_next  = mon_reg;
        day_next  = day_reg;
        hour_next = hour_reg;
        min_next  = min_reg;
        sec_next  = sec_reg;
        unique case (cmd)
            CMD_TICK: begin
                if (sec_reg < SEC_MAX) begin
                    sec_next = sec_reg + 1'b1;
                end else begin
                    sec_next = '0;
                    if (min_reg < MIN_MAX) begin
                        min_next = min_reg + 1'b1;
                    end else begin
                        min_next = '0;
                        if (hour_reg < HOUR_MAX) begin
                            hour_next = hour_reg + 1'b1;
                        end else begin
                            hour_next = '0;
                            if (day_reg < len) begin
                                day_next = day_reg + 1'b1;
                            end else begin
                                day_next = DAY_MIN;
                                if (mon_reg < MON_MAX) begin
                                    mon_next = mon_reg + 1'b1;
                                end else begin
                                    mon_next  = MON_MIN;
                                    year_next = year_reg + 1'b1;
                                end
                            end
                        end
                    end
                end
            end
            CMD_INC: begin
                case (fld)
                    FLD_SEC:  sec_next  = (sec_reg >= SEC_MAX) ? '0 : sec_reg + 1'b1;
                    FLD_MIN:  min_next  = (min_reg >= MIN_MAX) ? '0 : min_reg + 1'b1;
                    FLD_HOUR: hour_next = (hour_reg >= HOUR_MAX) ? '0 : hour_reg + 1'b1;
                    FLD_DAY:  day_next  = (day_reg >= len) ? DAY_MIN : day_reg + 1'b1;
                    FLD_MON:  mon_next  = (mon_reg >= MON_MAX || mon_reg < MON_MIN)
                                          ? MON_MIN : mon_reg + 1'b1;
                    FLD_YEAR: year_next = (year_reg >= year_hi_reg || year_reg < year_lo_reg)
                                          ? year_lo_reg : year_reg + 1'b1;
                    default: ;
                endcase
            end
            CMD_DEC: begin
                case (fld)
                    FLD_SEC:  sec_next  = (sec_reg == '0 || sec_reg > SEC_MAX)
                                          ? SEC_MAX : sec_reg - 1'b1;
                    FLD_MIN:  min_next  = (min_reg == '0 || min_reg > MIN_MAX)
                                          ? MIN_MAX : min_reg - 1'b1;
                    FLD_HOUR: hour_next = (hour_reg == '0 || hour_reg > HOUR_MAX)
                                          ? HOUR_MAX : hour_reg - 1'b1;
                    FLD_DAY:  day_next  = (day_reg <= DAY_MIN) ? len : day_reg - 1'b1;
                    FLD_MON:  mon_next  = (mon_reg <= MON_MIN || mon_reg > MON_MAX)
                                          ? MON_MAX : mon_reg - 1'b1;
                    FLD_YEAR: year_next = (year_reg <= year_lo_reg || year_reg > year_hi_reg)
                                          ? year_hi_reg : year_reg - 1'b1;
                    default: ;
                endcase
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            year_reg     <= YEAR_RST;
            mon_reg      <= MON_RST;
            day_reg      <= DAY_RST;
            hour_reg     <= HOUR_RST;
            min_reg      <= MIN_RST;
            sec_reg      <= SEC_RST;
            year_lo_reg  <= YEAR_LO_RST;
            year_hi_reg  <= YEAR_HI_RST;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (accept) begin
                year_reg <= year_next;
                mon_reg  <= mon_next;
                day_reg  <= day_next;
                hour_reg <= hour_next;
                min_reg  <= min_next;
                sec_reg  <= sec_next;
            end
            if (accept) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            if (cfg_wr_en) begin
                if (cfg_addr == REG_YEAR_LO) begin
                    year_lo_reg <= cfg_wdata;
                end else begin
                    year_hi_reg <= cfg_wdata;
                end
            end
        end
    end

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |-> !(m_tvalid_reg && !m_tready))
        else $error("word accepted over a stalled result");

    a_result_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> m_tvalid)
        else $error("accepted word produced no result");

    a_time_range: assert property (@(posedge aclk) disable iff (!aresetn)
        sec_reg <= SEC_MAX && min_reg <= MIN_MAX && hour_reg <= HOUR_MAX)
        else $error("time field out of range");

    a_date_range: assert property (@(posedge aclk) disable iff (!aresetn)
        mon_reg >= MON_MIN && mon_reg <= MON_MAX && day_reg >= DAY_MIN)
        else $error("date field out of range");

endmodule
`default_nettype wire

// ===== dv/tb_calendar_clock_counter.sv =====
// Self-checking testbench for calendar_clock_counter: tick and edit words vs. a predictor.
module tb_calendar_clock_counter;
    timeunit 1ns;
    timeprecision 1ps;

    import cal_clk_pkg::*;

    localparam logic [1:0] CMD_NOP    = 2'd3;
    localparam logic [2:0] FLD_SPARE6 = 3'd6;
    localparam logic [2:0] FLD_SPARE7 = 3'd7;
    localparam int STALL_LIMIT        = 2000;
    localparam int WORDS_PER_PHASE    = 90;

    typedef struct {
        logic [YEAR_W-1:0] yr;
        logic [MON_W-1:0]  mon;
        logic [DAY_W-1:0]  day;
        logic [HOUR_W-1:0] hr;
        logic [MIN_W-1:0]  mn;
        logic [SEC_W-1:0]  sc;
    } stamp_t;

    typedef enum {RX_OPEN, RX_COIN, RX_SPARSE, RX_CADENCE} rx_mode_t;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata   = '0;   // command[1:0], field_select[4:2], zero pad
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [39:0] m_tdata;          // year, month, day, hour, minute, second, zero pad
    logic        cfg_wr_en = 1'b0;
    logic        cfg_addr  = 1'b0;
    logic [11:0] cfg_wdata = '0;

    stamp_t            cal = '{YEAR_RST, MON_RST, DAY_RST, HOUR_RST, MIN_RST, SEC_RST};
    logic [YEAR_W-1:0] yr_floor = YEAR_LO_RST;
    logic [YEAR_W-1:0] yr_ceil  = YEAR_HI_RST;
    stamp_t            calendar_q[$];
    int                errors      = 0;
    int                words_sent  = 0;
    int                words_seen  = 0;
    int                burst_left  = 0;
    int                quiet       = 0;
    rx_mode_t          rx_mode     = RX_OPEN;
    int                rx_left     = 0;

    calendar_clock_counter i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cfg_wr_en(cfg_wr_en),
        .cfg_addr (cfg_addr),
        .cfg_wdata(cfg_wdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // ---------------- calendar predictor ----------------

    function automatic int days_of(logic [MON_W-1:0] mon, logic [YEAR_W-1:0] yr);
        case (mon)
            MON_FEB: return (yr % 4 == 0) ? 29 : 28;
            MON_APR, MON_JUN, MON_SEP, MON_NOV: return 30;
            default: return 31;
        endcase
    endfunction

    function automatic int wrap_up(int v, int lo, int hi);
        return (v >= hi || v < lo) ? lo : v + 1;
    endfunction

    function automatic int wrap_down(int v, int lo, int hi);
        return (v <= lo || v > hi) ? hi : v - 1;
    endfunction

    function automatic void tick_second();
        if (cal.sc < SEC_MAX) begin
            cal.sc = cal.sc + 1'b1;
        end else begin
            cal.sc = '0;
            if (cal.mn < MIN_MAX) begin
                cal.mn = cal.mn + 1'b1;
            end else begin
                cal.mn = '0;
                if (cal.hr < HOUR_MAX) begin
                    cal.hr = cal.hr + 1'b1;
                end else begin
                    cal.hr = '0;
                    if (cal.day < days_of(cal.mon, cal.yr)) begin
                        cal.day = cal.day + 1'b1;
                    end else begin
                        cal.day = DAY_MIN;
                        if (cal.mon < MON_MAX) begin
                            cal.mon = cal.mon + 1'b1;
                        end else begin
                            cal.mon = MON_MIN;
                            cal.yr  = cal.yr + 1'b1;
                        end
                    end
                end
            end
        end
    endfunction

    function automatic void edit_field(logic up, logic [2:0] sel);
        int len;
        case (sel)
            FLD_SEC:  cal.sc  = SEC_W'(up ? wrap_up(cal.sc, 0, SEC_MAX)
                                         : wrap_down(cal.sc, 0, SEC_MAX));
            FLD_MIN:  cal.mn  = MIN_W'(up ? wrap_up(cal.mn, 0, MIN_MAX)
                                         : wrap_down(cal.mn, 0, MIN_MAX));
            FLD_HOUR: cal.hr  = HOUR_W'(up ? wrap_up(cal.hr, 0, HOUR_MAX)
                                          : wrap_down(cal.hr, 0, HOUR_MAX));
            FLD_DAY: begin
                len = days_of(cal.mon, cal.yr);
                if (up)
                    cal.day = (cal.day >= len) ? DAY_MIN : cal.day + 1'b1;
                else
                    cal.day = (cal.day <= DAY_MIN) ? DAY_W'(len) : cal.day - 1'b1;
            end
            FLD_MON:  cal.mon = MON_W'(up ? wrap_up(cal.mon, MON_MIN, MON_MAX)
                                         : wrap_down(cal.mon, MON_MIN, MON_MAX));
            FLD_YEAR: cal.yr  = YEAR_W'(up ? wrap_up(cal.yr, yr_floor, yr_ceil)
                                          : wrap_down(cal.yr, yr_floor, yr_ceil));
            default: ;
        endcase
    endfunction

    function automatic void apply_word(logic [1:0] cmd, logic [2:0] sel);
        case (cmd)
            CMD_TICK: tick_second();
            CMD_INC:  edit_field(1'b1, sel);
            CMD_DEC:  edit_field(1'b0, sel);
            default: ;
        endcase
        calendar_q.push_back(cal);
    endfunction

    // ---------------- bus drivers ----------------

    task automatic send_word(input logic [1:0] cmd, input logic [2:0] sel);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(1, 8);
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 90)
                                                     : $urandom_range(1, 12);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= {3'b000, sel, cmd};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        apply_word(cmd, sel);
        words_sent++;
    endtask

    task automatic wait_results_drained();
        s_tvalid <= 1'b0;
        burst_left = 0;
        while (calendar_q.size() != 0) @(posedge aclk);
        repeat (2) @(posedge aclk);
    endtask

    task automatic write_reg(cfg_reg_t idx, logic [YEAR_W-1:0] value);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
        if (idx == REG_YEAR_LO)
            yr_floor = value;
        else
            yr_ceil = value;
    endtask

    task automatic set_year_window(logic [YEAR_W-1:0] lo, logic [YEAR_W-1:0] hi);
        wait_results_drained();
        write_reg(REG_YEAR_LO, lo);
        write_reg(REG_YEAR_HI, hi);
    endtask

    // walk one field to a value with the fewest edits
    task automatic steer(field_t f, int target);
        int v, lo, hi, span, ups;
        forever begin
            lo = 0;
            case (f)
                FLD_SEC:  begin v = cal.sc; hi = SEC_MAX; end
                FLD_MIN:  begin v = cal.mn; hi = MIN_MAX; end
                FLD_HOUR: begin v = cal.hr; hi = HOUR_MAX; end
                FLD_DAY:  begin v = cal.day; lo = DAY_MIN; hi = days_of(cal.mon, cal.yr); end
                default:  begin v = cal.mon; lo = MON_MIN; hi = MON_MAX; end
            endcase
            if (v == target) break;
            span = hi - lo + 1;
            ups  = (target - v + span) % span;
            if (v > hi || 2 * ups > span)
                send_word(CMD_DEC, f);
            else
                send_word(CMD_INC, f);
        end
    endtask

    // park the lower fields at their last value, then tick through the carry
    task automatic run_to_rollover(int depth);
        if (depth >= 5) steer(FLD_MON, MON_MAX);
        if (depth >= 4) steer(FLD_DAY, days_of(cal.mon, cal.yr));
        if (depth >= 3) steer(FLD_HOUR, HOUR_MAX);
        if (depth >= 2) steer(FLD_MIN, MIN_MAX);
        if (depth >= 1) steer(FLD_SEC, SEC_MAX);
        repeat ($urandom_range(1, 3)) send_word(CMD_TICK, 3'($urandom_range(0, 7)));
    endtask

    // ---------------- result side ----------------

    task automatic report_mismatch(string what, int got, int want);
        $display("ERROR: word %0d %s got %0d expected %0d", words_seen, what, got, want);
        errors++;
    endtask

    always @(posedge aclk) begin
        if (rx_left == 0) begin
            rx_mode = rx_mode_t'($urandom_range(0, 3));
            rx_left = $urandom_range(10, 80);
        end
        rx_left--;
        case (rx_mode)
            RX_OPEN:   m_tready <= 1'b1;
            RX_COIN:   m_tready <= ($urandom_range(0, 1) == 1);
            RX_SPARSE: m_tready <= ($urandom_range(0, 3) == 0);
            default:   m_tready <= rx_left[1];
        endcase
    end

    always @(posedge aclk) begin : check_words
        stamp_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got.yr  = m_tdata[11:0];
            got.mon = m_tdata[15:12];
            got.day = m_tdata[20:16];
            got.hr  = m_tdata[25:21];
            got.mn  = m_tdata[31:26];
            got.sc  = m_tdata[37:32];
            if (calendar_q.size() == 0) begin
                report_mismatch("arrived with nothing pending, year", got.yr, 0);
            end else begin
                want = calendar_q.pop_front();
                if (got.yr !== want.yr)   report_mismatch("year", got.yr, want.yr);
                if (got.mon !== want.mon) report_mismatch("month", got.mon, want.mon);
                if (got.day !== want.day) report_mismatch("day", got.day, want.day);
                if (got.hr !== want.hr)   report_mismatch("hour", got.hr, want.hr);
                if (got.mn !== want.mn)   report_mismatch("minute", got.mn, want.mn);
                if (got.sc !== want.sc)   report_mismatch("second", got.sc, want.sc);
            end
            words_seen++;
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet = 0;
        else
            quiet++;
        if (quiet >= STALL_LIMIT) begin
            $display("ERROR: no word moved for %0d cycles", STALL_LIMIT);
            $display("DONE: errors detected");
            $finish;
        end
    end

    // ---------------- tests ----------------

    // reset time is 23:59:57 on Feb 28 of a leap year
    task automatic test_power_on_rollover();
        repeat (4) send_word(CMD_TICK, FLD_SEC);
    endtask

    task automatic test_spare_codes();
        send_word(CMD_NOP, FLD_SEC);
        send_word(CMD_NOP, FLD_SPARE7);
        send_word(CMD_INC, FLD_SPARE6);
        send_word(CMD_DEC, FLD_SPARE7);
        send_word(CMD_INC, FLD_SPARE7);
        send_word(CMD_DEC, FLD_SPARE6);
    endtask

    task automatic test_each_field_edit();
        for (int i = FLD_SEC; i <= FLD_YEAR; i++) begin
            send_word(CMD_INC, i[2:0]);
            send_word(CMD_DEC, i[2:0]);
        end
    endtask

    task automatic test_day_past_month_end();
        steer(FLD_MON, MON_MIN);
        steer(FLD_DAY, 31);
        send_word(CMD_INC, FLD_MON);    // Feb 31
        run_to_rollover(3);             // carry starts March
        steer(FLD_DAY, 31);
        send_word(CMD_INC, FLD_MON);    // Apr 31
        send_word(CMD_INC, FLD_DAY);
        send_word(CMD_DEC, FLD_MON);
        send_word(CMD_DEC, FLD_DAY);
        send_word(CMD_INC, FLD_MON);    // Apr 31 again
        send_word(CMD_DEC, FLD_DAY);
    endtask

    task automatic test_year_wrap();
        set_year_window(12'd4095, 12'd4095);
        send_word(CMD_INC, FLD_YEAR);
        run_to_rollover(5);             // year 4095 carries to 0
        send_word(CMD_INC, FLD_YEAR);
        send_word(CMD_DEC, FLD_YEAR);
        set_year_window(12'd0, 12'd4095);
        send_word(CMD_INC, FLD_YEAR);
        send_word(CMD_DEC, FLD_YEAR);
        send_word(CMD_DEC, FLD_YEAR);
    endtask

    task automatic test_inverted_window();
        set_year_window(12'd3000, 12'd1000);
        send_word(CMD_INC, FLD_YEAR);
        send_word(CMD_INC, FLD_YEAR);
        send_word(CMD_DEC, FLD_YEAR);
        send_word(CMD_DEC, FLD_YEAR);
        send_word(CMD_TICK, FLD_YEAR);
    endtask

    task automatic random_phase(int quota);
        int stop_at, pick;
        logic [4:0] raw;
        stop_at = words_sent + quota;
        while (words_sent < stop_at) begin
            pick = $urandom_range(0, 99);
            if (pick < 45) begin
                run_to_rollover($urandom_range(0, 5));
            end else if (pick < 78) begin
                repeat ($urandom_range(1, 6))
                    send_word(2'($urandom_range(CMD_INC, CMD_DEC)),
                              3'($urandom_range(FLD_SEC, FLD_YEAR)));
            end else if (pick < 90) begin
                repeat ($urandom_range(1, 10)) send_word(CMD_TICK, 3'($urandom_range(0, 7)));
            end else if (pick < 98) begin
                raw = 5'($urandom);
                send_word(raw[1:0], raw[4:2]);
            end else begin
                wait_results_drained();
            end
        end
    endtask

    task automatic test_random_traffic();
        int lo, hi;
        for (int phase = 0; phase < 5; phase++) begin
            case (phase)
                0: begin lo = YEAR_LO_RST; hi = YEAR_HI_RST; end
                1: begin lo = 0; hi = 4095; end
                2: begin lo = 4095; hi = 0; end
                3: begin lo = $urandom_range(0, 4095); hi = $urandom_range(lo, 4095); end
                default: begin lo = $urandom_range(0, 4095); hi = lo; end
            endcase
            set_year_window(lo[YEAR_W-1:0], hi[YEAR_W-1:0]);
            random_phase(WORDS_PER_PHASE);
        end
    endtask

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        test_power_on_rollover();
        test_spare_codes();
        test_each_field_edit();
        test_day_past_month_end();
        test_year_wrap();
        test_inverted_window();
        test_random_traffic();
        wait_results_drained();
        repeat (4) @(posedge aclk);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// ===== files.f =====
src/cal_clk_pkg.sv
src/calendar_clock_counter.sv
dv/tb_calendar_clock_counter.sv
